@@ rtl/dsso_pkg.sv @@
package dsso_pkg;

  localparam int DSSO_QUEUE_DEPTH = 64;
  localparam int CYL_W            = 16;
  localparam int CFG_INDEX_W      = 1;
  localparam int CFG_DATA_W       = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_HEAD_POSITION = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SWEEP_MODE    = 1'd1;

  localparam logic MODE_ELEVATOR = 1'b0;
  localparam logic MODE_CIRCULAR = 1'b1;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_PUSH   = 2'd2,
    CELL_POP    = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [CYL_W-1:0]   key;
    logic [CYL_W-1:0]   push_data;
  } chain_ctrl_t;

  typedef struct packed {
    logic               top_vld;
    logic [CYL_W-1:0]   top_val;
  } chain_stat_t;

endpackage

@@ rtl/dsso_if.sv @@
interface dsso_req_if import dsso_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CYL_W-1:0] cylinder;
  logic             last_request;

  modport source (output valid, output cylinder, output last_request, input ready);
  modport sink   (input valid, input cylinder, input last_request, output ready);
endinterface

interface dsso_res_if import dsso_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CYL_W-1:0] served_cylinder;
  logic             end_of_order;
  logic             overflow;

  modport source (output valid, output served_cylinder, output end_of_order,
                  output overflow, input ready);
  modport sink   (input valid, input served_cylinder, input end_of_order,
                  input overflow, output ready);
endinterface

@@ rtl/dsso_cell.sv @@
module dsso_cell import dsso_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cell_op_t         op,
  input  logic [CYL_W-1:0] key,
  input  logic [CYL_W-1:0] left_val,
  input  logic             left_vld,
  input  logic             left_gt,
  input  logic [CYL_W-1:0] right_val,
  input  logic             right_vld,
  output logic [CYL_W-1:0] val,
  output logic             vld,
  output logic             gt
);

  logic [CYL_W-1:0] val_next;
  logic             vld_next;

  // An empty cell counts as greater than any key, so the new entry lands in
  // the first cell whose content is strictly greater (after equal entries).
  assign gt = !vld || (val > key);

  always_comb begin
    val_next = val;
    vld_next = vld;
    unique case (op)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        if (left_gt) begin
          val_next = left_val;
          vld_next = left_vld;
        end else if (gt) begin
          val_next = key;
          vld_next = 1'b1;
        end
      end
      CELL_PUSH: begin
        val_next = left_val;
        vld_next = left_vld;
      end
      CELL_POP: begin
        val_next = right_val;
        vld_next = right_vld;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

@@ rtl/dsso_chain.sv @@
module dsso_chain import dsso_pkg::*; #(
  parameter int DEPTH = DSSO_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  chain_ctrl_t ctrl,
  output chain_stat_t stat
);

  logic [CYL_W-1:0] val      [DEPTH];
  logic             vld      [DEPTH];
  logic             gt       [DEPTH];
  logic [CYL_W-1:0] left_val [DEPTH];
  logic             left_vld [DEPTH];
  logic             left_gt  [DEPTH];
  logic [CYL_W-1:0] right_val[DEPTH];
  logic             right_vld[DEPTH];

  // The front cell sees the push data on its left and nothing greater.
  assign left_val[0] = ctrl.push_data;
  assign left_vld[0] = 1'b1;
  assign left_gt[0]  = 1'b0;

  assign right_val[DEPTH-1] = '0;
  assign right_vld[DEPTH-1] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i > 0) begin : g_left
      assign left_val[i] = val[i-1];
      assign left_vld[i] = vld[i-1];
      assign left_gt[i]  = gt[i-1];
    end
    if (i < DEPTH - 1) begin : g_right
      assign right_val[i] = val[i+1];
      assign right_vld[i] = vld[i+1];
    end

    dsso_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (ctrl.op),
      .key       (ctrl.key),
      .left_val  (left_val[i]),
      .left_vld  (left_vld[i]),
      .left_gt   (left_gt[i]),
      .right_val (right_val[i]),
      .right_vld (right_vld[i]),
      .val       (val[i]),
      .vld       (vld[i]),
      .gt        (gt[i])
    );
  end

  assign stat.top_val = val[0];
  assign stat.top_vld = vld[0];

endmodule

@@ rtl/disk_request_scan_order_top.sv @@
// Collection: one request accepted per cycle while idle; each is inserted in sorted order
// (dropped and flagged as overflow when full). After the last request the cylinders below
// the head move to a side chain; then beats leave at most one per cycle when not stalled:
// up from the head, then down the side chain (elevator) or, after a refill, up from the
// lowest (circular). Requests are accepted again once the final beat is loaded into the
// output register. Synchronous reset empties both chains, clears count and overflow.
module disk_request_scan_order_top import dsso_pkg::*; #(
  parameter int QUEUE_DEPTH = DSSO_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  dsso_req_if.sink               req,
  dsso_res_if.source             res
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOWER  = 6'b000010,
    S_UPPER  = 6'b000100,
    S_REFILL = 6'b001000,
    S_WRAP   = 6'b010000,
    S_DOWN   = 6'b100000
  } state_t;

  state_t            state, state_next;
  logic [CYL_W-1:0]  head_position;
  logic              sweep_mode;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  remaining, remaining_next;
  logic              dropped, dropped_next;

  logic              out_valid;
  logic [CYL_W-1:0]  out_cylinder;
  logic              out_end;
  logic              out_overflow;

  chain_ctrl_t       a_ctrl, b_ctrl;
  chain_stat_t       a_stat, b_stat;

  logic              accept;
  logic              has_room;
  logic              load_ok;
  logic              emit;
  logic [CYL_W-1:0]  emit_val;
  logic              emit_last;

  dsso_chain #(.DEPTH(QUEUE_DEPTH)) u_sorted (
    .clk  (clk),
    .rst  (rst),
    .ctrl (a_ctrl),
    .stat (a_stat)
  );

  // Side chain: a stack that holds the cylinders below the head.
  dsso_chain #(.DEPTH(QUEUE_DEPTH)) u_side (
    .clk  (clk),
    .rst  (rst),
    .ctrl (b_ctrl),
    .stat (b_stat)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign has_room  = (count < CNT_W'(QUEUE_DEPTH));
  assign load_ok   = !out_valid || res.ready;
  assign emit_last = (remaining == CNT_W'(1));

  always_comb begin
    state_next       = state;
    count_next       = count;
    remaining_next   = remaining;
    dropped_next     = dropped;
    emit             = 1'b0;
    emit_val         = a_stat.top_val;
    a_ctrl.op        = CELL_HOLD;
    a_ctrl.key       = req.cylinder;
    a_ctrl.push_data = b_stat.top_val;
    b_ctrl.op        = CELL_HOLD;
    b_ctrl.key       = '0;
    b_ctrl.push_data = a_stat.top_val;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (has_room) begin
            a_ctrl.op  = CELL_INSERT;
            count_next = count + CNT_W'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (req.last_request) begin
            remaining_next = has_room ? count + CNT_W'(1) : count;
            state_next     = S_LOWER;
          end
        end
      end
      S_LOWER: begin
        if (a_stat.top_vld && (a_stat.top_val < head_position)) begin
          a_ctrl.op = CELL_POP;
          b_ctrl.op = CELL_PUSH;
        end else begin
          state_next = S_UPPER;
        end
      end
      S_UPPER: begin
        if (a_stat.top_vld) begin
          if (load_ok) begin
            emit      = 1'b1;
            emit_val  = a_stat.top_val;
            a_ctrl.op = CELL_POP;
          end
        end else if (sweep_mode == MODE_CIRCULAR) begin
          state_next = S_REFILL;
        end else begin
          state_next = S_DOWN;
        end
      end
      S_REFILL: begin
        // Popping the stack back onto the sorted chain restores ascending order.
        if (b_stat.top_vld) begin
          b_ctrl.op = CELL_POP;
          a_ctrl.op = CELL_PUSH;
        end else begin
          state_next = S_WRAP;
        end
      end
      S_WRAP: begin
        if (load_ok && a_stat.top_vld) begin
          emit      = 1'b1;
          emit_val  = a_stat.top_val;
          a_ctrl.op = CELL_POP;
        end
      end
      S_DOWN: begin
        if (load_ok && b_stat.top_vld) begin
          emit      = 1'b1;
          emit_val  = b_stat.top_val;
          b_ctrl.op = CELL_POP;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (emit) begin
      remaining_next = remaining - CNT_W'(1);
      if (emit_last) begin
        state_next   = S_IDLE;
        count_next   = '0;
        dropped_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      remaining     <= '0;
      dropped       <= 1'b0;
      head_position <= '0;
      sweep_mode    <= MODE_ELEVATOR;
      out_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      dropped   <= dropped_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HEAD_POSITION: head_position <= cfg_data[CYL_W-1:0];
          REG_SWEEP_MODE:    sweep_mode    <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_cylinder <= emit_val;
      out_end      <= emit_last;
      out_overflow <= dropped;
    end
  end

  assign res.valid           = out_valid;
  assign res.served_cylinder = out_cylinder;
  assign res.end_of_order    = out_end;
  assign res.overflow        = out_overflow;

  a_busy_has_work: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (remaining != '0))
    else $error("batch in progress with no beats left to send");

  a_wrap_source: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRAP) |-> a_stat.top_vld)
    else $error("wrap phase with empty sorted chain");

  a_down_source: assert property (@(posedge clk) disable iff (rst)
    (state == S_DOWN) |-> b_stat.top_vld)
    else $error("downward phase with empty side chain");

  a_side_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !b_stat.top_vld)
    else $error("side chain holds entries between batches");

  a_final_to_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_last) |=> (state == S_IDLE) && (count == '0) && !a_stat.top_vld)
    else $error("final beat left entries or state behind");

endmodule
